// ===== rtl/sstf_pkg.sv =====
// sstf_pkg: shared types and constants for the shortest-seek-first scheduler
// no dependencies; imported by every module of the block
`default_nettype none

package sstf_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int CYL_W           = 16;
  localparam int SUM_W           = 22;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [CYL_W-1:0] cylinder;
  } in_item_t;

  typedef struct packed {
    logic [CYL_W-1:0] target;
    logic [CYL_W-1:0] seek_distance;
    logic [SUM_W-1:0] total_seek;
    logic             is_last;
    logic             queue_empty;
  } out_item_t;

  // result of the shared distance/compare unit
  typedef struct packed {
    logic [CYL_W-1:0] seek_d;
    logic             take;
  } cmp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT,
    ST_EMPTY
  } state_t;

endpackage : sstf_pkg

`default_nettype wire

// ===== rtl/shortest_seek_first_scheduler.sv =====
// shortest_seek_first_scheduler: a load item gives no result.
// run with n pending entries: each result needs a scan of the table through the
// single memory read port and the shared compare unit, then the drain and emit
// states; an empty run result becomes valid in the same cycle that the input is
// free again. output stalls hold the emit and empty states.
// rst_n (synchronous, active low) clears the fsm, table count, served marks and
// output valid; table contents stay undefined until written.
`default_nettype none

module shortest_seek_first_scheduler
  import sstf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         k_r, k_nxt;
  logic [IDX_W-1:0]         j_r, j_nxt;
  logic [QUEUE_DEPTH-1:0]   served_r, served_nxt;
  logic [CYL_W-1:0]         head_r, head_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [IDX_W-1:0]         best_idx_r, best_idx_nxt;
  logic [CYL_W-1:0]         best_d_r, best_d_nxt;
  logic [CYL_W-1:0]         best_cyl_r, best_cyl_nxt;
  logic                     found_r, found_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r, out_item_nxt;

  logic                     in_fire;
  logic                     slot_free;
  logic                     last_svc;
  logic                     scan_end;
  logic [IDX_W-1:0]         last_idx;
  logic                     mem_we;
  logic [CYL_W-1:0]         rd_data;
  cmp_t                     cmp;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign last_idx  = IDX_W'(count_r - 1'b1);
  assign scan_end  = (j_r == last_idx);
  assign last_svc  = (CNT_W'(k_r + 1'b1) == count_r);
  assign mem_we    = in_fire && (in_item.mode == MODE_LOAD) &&
                     (count_r != CNT_W'(QUEUE_DEPTH));

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  sstf_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_item.cylinder),
    .raddr (j_r),
    .rdata (rd_data)
  );

  sstf_dist_unit u_dist (
    .cand   (rd_data),
    .head   (head_r),
    .best_d (best_d_r),
    .found  (found_r),
    .cmp    (cmp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_item.mode == MODE_RUN)) begin
          state_nxt = (count_r == '0) ? ST_EMPTY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = last_svc ? ST_IDLE : ST_SCAN;
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt     = count_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    served_nxt    = served_r;
    head_nxt      = head_r;
    sum_nxt       = sum_r;
    best_idx_nxt  = best_idx_r;
    best_d_nxt    = best_d_r;
    best_cyl_nxt  = best_cyl_r;
    found_nxt     = found_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = j_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;

    // compare the entry read last cycle against the best so far
    if (rd_vld_r && !served_r[rd_idx_r] && cmp.take) begin
      best_idx_nxt = rd_idx_r;
      best_d_nxt   = cmp.seek_d;
      best_cyl_nxt = rd_data;
      found_nxt    = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (mem_we) begin
          count_nxt = CNT_W'(count_r + 1'b1);
        end
        if (in_fire && (in_item.mode == MODE_RUN)) begin
          head_nxt  = in_item.cylinder;
          sum_nxt   = '0;
          k_nxt     = '0;
          j_nxt     = '0;
          found_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = j_r;
        if (!scan_end) begin
          j_nxt = IDX_W'(j_r + 1'b1);
        end
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        if (slot_free) begin
          served_nxt[best_idx_r] = 1'b1;
          head_nxt      = best_cyl_r;
          sum_nxt       = sum_r + SUM_W'(best_d_r);
          k_nxt         = CNT_W'(k_r + 1'b1);
          j_nxt         = '0;
          found_nxt     = 1'b0;
          out_valid_nxt = 1'b1;
          out_item_nxt.target        = best_cyl_r;
          out_item_nxt.seek_distance = best_d_r;
          out_item_nxt.total_seek    = sum_r + SUM_W'(best_d_r);
          out_item_nxt.is_last       = last_svc;
          out_item_nxt.queue_empty   = 1'b0;
          if (last_svc) begin
            count_nxt  = '0;
            served_nxt = '0;
          end
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '0;
          out_item_nxt.queue_empty = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      served_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      served_r    <= served_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    head_r     <= head_nxt;
    sum_r      <= sum_nxt;
    best_idx_r <= best_idx_nxt;
    best_d_r   <= best_d_nxt;
    best_cyl_r <= best_cyl_nxt;
    found_r    <= found_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule : shortest_seek_first_scheduler

`default_nettype wire

// ===== rtl/sstf_store.sv =====
// sstf_store: request table, one write port and one registered read port
// depends on sstf_pkg for the cylinder width
`default_nettype none

module sstf_store
  import sstf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire logic [CYL_W-1:0] wdata,
  input  wire logic [IDX_W-1:0] raddr,
  output logic      [CYL_W-1:0] rdata
);

  logic [CYL_W-1:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : sstf_store

`default_nettype wire

// ===== rtl/sstf_dist_unit.sv =====
// sstf_dist_unit: shared absolute-distance and nearest-so-far compare
// depends on sstf_pkg for cmp_t
`default_nettype none

module sstf_dist_unit
  import sstf_pkg::*;
(
  input  wire logic [CYL_W-1:0] cand,
  input  wire logic [CYL_W-1:0] head,
  input  wire logic [CYL_W-1:0] best_d,
  input  wire logic             found,
  output cmp_t                  cmp
);

  logic [CYL_W-1:0] seek_d;

  always_comb begin
    seek_d     = (cand >= head) ? (cand - head) : (head - cand);
    cmp.seek_d = seek_d;
    // strict less keeps the lowest slot on a tie
    cmp.take   = !found || (seek_d < best_d);
  end

endmodule : sstf_dist_unit

`default_nettype wire

// ===== rtl/sstf_checker.sv =====
// sstf_checker: port-level assertions for the scheduler, bound to the top level
// depends on sstf_pkg for the item types
`default_nettype none

module sstf_checker
  import sstf_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  // empty-table result carries nothing else
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.queue_empty |->
      out_item.target == '0 && out_item.seek_distance == '0 &&
      out_item.total_seek == '0 && !out_item.is_last)
    else $error("empty result with nonzero fields");

  // a run keeps the input side busy
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.mode == MODE_RUN |=> in_stall)
    else $error("input taken right after a run item");

  // more services pending after a non-final result
  a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.is_last && !out_item.queue_empty |-> in_stall)
    else $error("scheduler idle with services pending");

endmodule : sstf_checker

bind shortest_seek_first_scheduler sstf_checker u_sstf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
